/* rtl/tst_pkg.sv */
// shared types and constants for the thread slot table
`timescale 1ns / 1ps

package tst_pkg;

   localparam int ACTION_W     = 3;
   localparam int SLOT_FIELD_W = 4;
   localparam int ID_FIELD_W   = 16;
   localparam int VALUE_W      = 32;
   localparam int STATUS_W     = 2;
   localparam int MAX_RESULTS  = 8;
   // queue depth is a power of two so the pointers wrap on their own
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [ACTION_W-1:0] {
      OP_SPAWN     = 3'd0,
      OP_FORK      = 3'd1,
      OP_KILL_SLOT = 3'd2,
      OP_KILL_ID   = 3'd3,
      OP_LOOKUP    = 3'd4,
      OP_BLOCK     = 3'd5,
      OP_NOTIFY    = 3'd6,
      OP_BAD       = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY    = 2'd0,
      SLOT_RUNNABLE = 2'd1,
      SLOT_BLOCKED  = 2'd2
   } slot_state_type;

   typedef enum logic [3:0] {
      ENG_IDLE,
      ENG_DISPATCH,
      ENG_FIND,
      ENG_FORK_RD,
      ENG_KILL_RD,
      ENG_BLOCK_RD,
      ENG_SCAN,
      ENG_NOTE_RD,
      ENG_WAKE_SCAN,
      ENG_WAKE_SEEK,
      ENG_WAKE_RD,
      ENG_EMIT
   } eng_state_type;

   typedef struct packed {
      op_type                  op;
      logic [SLOT_FIELD_W-1:0] slot;
      logic                    fail;
      logic [ID_FIELD_W-1:0]   tid;
      logic [VALUE_W-1:0]      value;
   } cmd_type;

   typedef struct packed {
      status_type              status;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [ID_FIELD_W-1:0]   id;
      logic [VALUE_W-1:0]      value;
      logic                    last;
   } rsp_type;

endpackage

/* rtl/tst_front.sv */
// front end: takes request items and classifies them into commands
`timescale 1ns / 1ps

module tst_front #(
   parameter int SLOT_COUNT = 8
) (
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tst_pkg::ACTION_W-1:0]    req_action,
   input  logic [tst_pkg::SLOT_FIELD_W-1:0] req_slot,
   input  logic [tst_pkg::ID_FIELD_W-1:0]  req_thread_id,
   input  logic [tst_pkg::VALUE_W-1:0]     req_pass_value,
   input  logic                            q_full,
   output logic                            q_push,
   output tst_pkg::cmd_type                q_cmd
);
   import tst_pkg::*;

   op_type op;
   logic   in_range;
   logic   fail;

   assign op       = op_type'(req_action);
   assign in_range = (32'(req_slot) < SLOT_COUNT);

   // actions that name a slot fail early when it is out of range
   always_comb begin
      case (op)
         OP_SPAWN, OP_KILL_ID, OP_LOOKUP: begin
            fail = 1'b0;
         end
         OP_FORK, OP_KILL_SLOT, OP_BLOCK, OP_NOTIFY: begin
            fail = !in_range;
         end
         default: begin
            fail = 1'b1;
         end
      endcase
   end

   assign req_ready   = !q_full;
   assign q_push      = req_valid && !q_full;
   assign q_cmd.op    = op;
   assign q_cmd.slot  = req_slot;
   assign q_cmd.fail  = fail;
   assign q_cmd.tid   = req_thread_id;
   assign q_cmd.value = req_pass_value;

endmodule

/* rtl/tst_cmd_queue.sv */
// short command queue between front end and engine
`timescale 1ns / 1ps

module tst_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tst_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output tst_pkg::cmd_type pop_cmd
);
   import tst_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* rtl/tst_engine.sv */
// back end: slot table, id counter, slot scans and result register
`timescale 1ns / 1ps

module tst_engine #(
   parameter int SLOT_COUNT = 8,
   parameter int ID_WIDTH   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  tst_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tst_pkg::rsp_type rsp
);
   import tst_pkg::*;

   localparam int SW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);

   // slot record memory: id, waiting flag, awaited id
   logic [ID_WIDTH-1:0] mem_id  [SLOT_COUNT];
   logic                mem_wait[SLOT_COUNT];
   logic [ID_WIDTH-1:0] mem_awt [SLOT_COUNT];

   eng_state_type       state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [SW-1:0]       chk_idx_ff, chk_idx_in;
   logic [SW-1:0]       dest_ff, dest_in;
   logic [ID_WIDTH-1:0] nid_ff, nid_in;
   logic [SLOT_COUNT-1:0] mask_ff, mask_in;
   logic [CW-1:0]       total_ff, total_in;
   logic [CW-1:0]       n_ff, n_in;
   logic                more_ff, more_in;
   rsp_type             res_ff, res_in;
   logic                out_vld_ff, out_vld_in;
   rsp_type             out_ff, out_in;
   logic [ID_WIDTH-1:0] ctr_ff, ctr_in;
   slot_state_type      slot_state_ff [SLOT_COUNT];
   slot_state_type      slot_state_in [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] written_ff, written_in;

   logic                rd_en;
   logic [SW-1:0]       rd_addr;
   logic [ID_WIDTH-1:0] rd_id_ff, rd_awt_ff;
   logic                rd_wait_ff, rd_written_ff;
   logic                wr_en;
   logic [SW-1:0]       wr_addr;
   logic [ID_WIDTH-1:0] wr_id, wr_awt;
   logic                wr_wait;

   logic [SW-1:0]       s_idx, f_idx;
   logic [ID_WIDTH-1:0] tid_m, ctr_inc, new_id;
   logic [ID_WIDTH-1:0] rec_id, rec_awt;
   logic                rec_wait;
   logic                src_empty, f_empty, f_last;
   logic                issue_ok, chk_last, id_match, wake_hit, wake_last;
   logic                out_free;
   rsp_type             res_invalid, res_full;

   function automatic rsp_type ok_rsp(input logic [SW-1:0] slot,
                                      input logic [ID_WIDTH-1:0] id,
                                      input logic [VALUE_W-1:0] value,
                                      input logic last);
      rsp_type r;
      r.status = ST_OK;
      r.slot   = SLOT_FIELD_W'(slot);
      r.id     = ID_FIELD_W'(id);
      r.value  = value;
      r.last   = last;
      return r;
   endfunction

   assign res_invalid = '{status: ST_INVALID, slot: SLOT_FIELD_W'(SLOT_COUNT),
                          id: '0, value: '0, last: 1'b1};
   assign res_full    = '{status: ST_FULL, slot: SLOT_FIELD_W'(SLOT_COUNT),
                          id: '0, value: '0, last: 1'b1};

   assign s_idx     = SW'(cmd_ff.slot);
   assign f_idx     = SW'(idx_ff);
   assign tid_m     = ID_WIDTH'(cmd_ff.tid);
   assign ctr_inc   = ctr_ff + 1'b1;
   // counter skips zero
   assign new_id    = (ctr_inc == '0) ? ID_WIDTH'(1) : ctr_inc;
   // entries never written read as their reset value
   assign rec_id    = rd_written_ff ? rd_id_ff : '0;
   assign rec_wait  = rd_written_ff ? rd_wait_ff : 1'b0;
   assign rec_awt   = rd_written_ff ? rd_awt_ff : '0;
   assign src_empty = (slot_state_ff[s_idx] == SLOT_EMPTY);
   assign f_empty   = (slot_state_ff[f_idx] == SLOT_EMPTY);
   assign f_last    = (f_idx == SW'(SLOT_COUNT - 1));
   assign issue_ok  = (idx_ff < CW'(SLOT_COUNT));
   assign chk_last  = chk_vld_ff && (chk_idx_ff == SW'(SLOT_COUNT - 1));
   assign id_match  = chk_vld_ff && (slot_state_ff[chk_idx_ff] != SLOT_EMPTY) &&
                      (rec_id == tid_m);
   assign wake_hit  = chk_vld_ff && (slot_state_ff[chk_idx_ff] == SLOT_BLOCKED) &&
                      rec_wait && (rec_awt == nid_ff);
   assign wake_last = (32'(n_ff) == MAX_RESULTS - 1) ||
                      (CW'(n_ff + 1'b1) == total_ff);
   assign out_free  = !out_vld_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (q_valid) begin
               state_in = ENG_DISPATCH;
            end
         end
         ENG_DISPATCH: begin
            if (cmd_ff.fail) begin
               state_in = ENG_EMIT;
            end else begin
               case (cmd_ff.op)
                  OP_SPAWN, OP_FORK:     state_in = ENG_FIND;
                  OP_KILL_SLOT:          state_in = ENG_KILL_RD;
                  OP_BLOCK:              state_in = src_empty ? ENG_EMIT : ENG_BLOCK_RD;
                  OP_KILL_ID, OP_LOOKUP: state_in = ENG_SCAN;
                  OP_NOTIFY:             state_in = ENG_NOTE_RD;
                  default:               state_in = ENG_EMIT;
               endcase
            end
         end
         ENG_FIND: begin
            if (f_empty) begin
               if (cmd_ff.op == OP_FORK && !src_empty) begin
                  state_in = ENG_FORK_RD;
               end else begin
                  state_in = ENG_EMIT;
               end
            end else if (f_last) begin
               state_in = ENG_EMIT;
            end
         end
         ENG_FORK_RD, ENG_KILL_RD, ENG_BLOCK_RD, ENG_WAKE_RD: begin
            state_in = ENG_EMIT;
         end
         ENG_SCAN: begin
            if (id_match || chk_last) begin
               state_in = ENG_EMIT;
            end
         end
         ENG_NOTE_RD: begin
            state_in = ENG_WAKE_SCAN;
         end
         ENG_WAKE_SCAN: begin
            if (chk_last) begin
               if (mask_ff == '0 && !wake_hit) begin
                  state_in = ENG_EMIT;
               end else begin
                  state_in = ENG_WAKE_SEEK;
               end
            end
         end
         ENG_WAKE_SEEK: begin
            if (mask_ff[f_idx]) begin
               state_in = ENG_WAKE_RD;
            end
         end
         ENG_EMIT: begin
            if (out_free) begin
               state_in = more_ff ? ENG_WAKE_SEEK : ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   // datapath and table updates
   always_comb begin
      q_pop         = 1'b0;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      dest_in       = dest_ff;
      nid_in        = nid_ff;
      mask_in       = mask_ff;
      total_in      = total_ff;
      n_in          = n_ff;
      more_in       = more_ff;
      res_in        = res_ff;
      ctr_in        = ctr_ff;
      slot_state_in = slot_state_ff;
      written_in    = written_ff;
      rd_en         = 1'b0;
      rd_addr       = s_idx;
      wr_en         = 1'b0;
      wr_addr       = s_idx;
      wr_id         = rec_id;
      wr_wait       = rec_wait;
      wr_awt        = rec_awt;
      out_vld_in    = out_vld_ff && !rsp_ready;
      out_in        = out_ff;

      case (state_ff)
         ENG_IDLE: begin
            q_pop   = q_valid;
            cmd_in  = q_cmd;
            more_in = 1'b0;
         end
         ENG_DISPATCH: begin
            res_in     = res_invalid;
            idx_in     = '0;
            chk_vld_in = 1'b0;
            if (!cmd_ff.fail && (cmd_ff.op == OP_KILL_SLOT || cmd_ff.op == OP_NOTIFY ||
                                 (cmd_ff.op == OP_BLOCK && !src_empty))) begin
               rd_en = 1'b1;
            end
         end
         ENG_FIND: begin
            idx_in = idx_ff + 1'b1;
            if (f_empty) begin
               if (cmd_ff.op == OP_SPAWN) begin
                  slot_state_in[f_idx] = SLOT_RUNNABLE;
                  written_in[f_idx]    = 1'b1;
                  wr_en   = 1'b1;
                  wr_addr = f_idx;
                  wr_id   = new_id;
                  wr_wait = 1'b0;
                  wr_awt  = '0;
                  ctr_in  = new_id;
                  res_in  = ok_rsp(f_idx, new_id, '0, 1'b1);
               end else if (!src_empty) begin
                  rd_en   = 1'b1;
                  dest_in = f_idx;
               end
            end else if (f_last) begin
               res_in = res_full;
            end
         end
         ENG_FORK_RD: begin
            // the copy keeps state and wait target, only the id is fresh
            slot_state_in[dest_ff] = slot_state_ff[s_idx];
            written_in[dest_ff]    = 1'b1;
            wr_en   = 1'b1;
            wr_addr = dest_ff;
            wr_id   = new_id;
            ctr_in  = new_id;
            res_in  = ok_rsp(dest_ff, new_id, '0, 1'b1);
         end
         ENG_KILL_RD: begin
            slot_state_in[s_idx] = SLOT_EMPTY;
            res_in = ok_rsp(s_idx, rec_id, '0, 1'b1);
         end
         ENG_BLOCK_RD: begin
            slot_state_in[s_idx] = SLOT_BLOCKED;
            written_in[s_idx]    = 1'b1;
            wr_en   = 1'b1;
            wr_wait = 1'b1;
            wr_awt  = tid_m;
            res_in  = ok_rsp(s_idx, rec_id, '0, 1'b1);
         end
         ENG_SCAN: begin
            // read one slot ahead while the previous one is compared
            chk_vld_in = issue_ok;
            chk_idx_in = f_idx;
            if (issue_ok) begin
               rd_en   = 1'b1;
               rd_addr = f_idx;
               idx_in  = idx_ff + 1'b1;
            end
            if (id_match) begin
               if (cmd_ff.op == OP_KILL_ID) begin
                  slot_state_in[chk_idx_ff] = SLOT_EMPTY;
               end
               res_in = ok_rsp(chk_idx_ff, rec_id, '0, 1'b1);
            end
         end
         ENG_NOTE_RD: begin
            nid_in     = rec_id;
            idx_in     = '0;
            chk_vld_in = 1'b0;
            mask_in    = '0;
            total_in   = '0;
         end
         ENG_WAKE_SCAN: begin
            chk_vld_in = issue_ok;
            chk_idx_in = f_idx;
            if (issue_ok) begin
               rd_en   = 1'b1;
               rd_addr = f_idx;
               idx_in  = idx_ff + 1'b1;
            end
            if (wake_hit) begin
               slot_state_in[chk_idx_ff] = SLOT_RUNNABLE;
               mask_in[chk_idx_ff]       = 1'b1;
               total_in                  = total_ff + 1'b1;
            end
            if (chk_last) begin
               idx_in = '0;
               n_in   = '0;
            end
         end
         ENG_WAKE_SEEK: begin
            if (mask_ff[f_idx]) begin
               rd_en   = 1'b1;
               rd_addr = f_idx;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ENG_WAKE_RD: begin
            res_in  = ok_rsp(f_idx, rec_id, cmd_ff.value, wake_last);
            more_in = !wake_last;
         end
         ENG_EMIT: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_in     = res_ff;
               if (more_ff) begin
                  idx_in = idx_ff + 1'b1;
                  n_in   = n_ff + 1'b1;
               end
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // record memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_id[wr_addr]   <= wr_id;
         mem_wait[wr_addr] <= wr_wait;
         mem_awt[wr_addr]  <= wr_awt;
      end
      if (rd_en) begin
         rd_id_ff      <= mem_id[rd_addr];
         rd_wait_ff    <= mem_wait[rd_addr];
         rd_awt_ff     <= mem_awt[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      cmd_in_hold: begin
         cmd_ff     <= cmd_in;
         idx_ff     <= idx_in;
         chk_idx_ff <= chk_idx_in;
         dest_ff    <= dest_in;
         nid_ff     <= nid_in;
         mask_ff    <= mask_in;
         total_ff   <= total_in;
         n_ff       <= n_in;
         res_ff     <= res_in;
         out_ff     <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ENG_IDLE;
         chk_vld_ff <= 1'b0;
         more_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
         ctr_ff     <= '0;
         written_ff <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_state_ff[i] <= SLOT_EMPTY;
         end
      end else begin
         state_ff      <= state_in;
         chk_vld_ff    <= chk_vld_in;
         more_ff       <= more_in;
         out_vld_ff    <= out_vld_in;
         ctr_ff        <= ctr_in;
         written_ff    <= written_in;
         slot_state_ff <= slot_state_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp       = out_ff;

endmodule

/* rtl/thread_slot_table.sv */
// top level of the thread slot table
`timescale 1ns / 1ps
// spawn and fork walk the slots from zero to the first empty one (full when none is left),
// a fork then reads its source slot; kill slot and block read the named slot; kill id and
// lookup scan up to the matching slot; notify walks every slot, then seeks and reads each
// woken slot in turn, one result per woken slot up to MAX_RESULTS; failed checks go to emit
// one item at a time: an item holds the engine until its last result is emitted, a stalled result
// holds it in its emit step; a two-entry command queue keeps taking items meanwhile
// synchronous reset empties every slot and zeroes the id counter at once, no clearing pass

module thread_slot_table #(
   parameter int SLOT_COUNT = 8,
   parameter int ID_WIDTH   = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // request item
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tst_pkg::ACTION_W-1:0]     req_action,
   input  logic [tst_pkg::SLOT_FIELD_W-1:0] req_slot,
   input  logic [tst_pkg::ID_FIELD_W-1:0]   req_thread_id,
   input  logic [tst_pkg::VALUE_W-1:0]      req_pass_value,
   // result item
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tst_pkg::STATUS_W-1:0]     rsp_status,
   output logic [tst_pkg::SLOT_FIELD_W-1:0] rsp_result_slot,
   output logic [tst_pkg::ID_FIELD_W-1:0]   rsp_result_id,
   output logic [tst_pkg::VALUE_W-1:0]      rsp_woken_value,
   output logic                             rsp_last
);
   import tst_pkg::*;

   // front to queue
   logic    q_full;
   logic    q_push;
   cmd_type push_cmd;
   // queue to engine
   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;
   // engine result register
   rsp_type rsp;

   // decode and early range checks, no table state needed here
   tst_front #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_slot       (req_slot),
      .req_thread_id  (req_thread_id),
      .req_pass_value (req_pass_value),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (push_cmd)
   );

   // decouples request side from the slot engine
   tst_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd)
   );

   // slot table, id counter, scans, result register
   tst_engine #(
      .SLOT_COUNT (SLOT_COUNT),
      .ID_WIDTH   (ID_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // result item onto its ports
   assign rsp_status      = rsp.status;
   assign rsp_result_slot = rsp.slot;
   assign rsp_result_id   = rsp.id;
   assign rsp_woken_value = rsp.value;
   assign rsp_last        = rsp.last;

endmodule

/* rtl/tst_checker.sv */
// port-level checker for the thread slot table, bound to the top level
`timescale 1ns / 1ps

module tst_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [tst_pkg::ACTION_W-1:0]     req_action,
   input logic [tst_pkg::SLOT_FIELD_W-1:0] req_slot,
   input logic [tst_pkg::ID_FIELD_W-1:0]   req_thread_id,
   input logic [tst_pkg::VALUE_W-1:0]      req_pass_value,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [tst_pkg::STATUS_W-1:0]     rsp_status,
   input logic [tst_pkg::SLOT_FIELD_W-1:0] rsp_result_slot,
   input logic [tst_pkg::ID_FIELD_W-1:0]   rsp_result_id,
   input logic [tst_pkg::VALUE_W-1:0]      rsp_woken_value,
   input logic                             rsp_last
);
   import tst_pkg::*;

   logic [3:0] pending_ff, pending_in;
   logic       in_run_ff, in_run_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // items accepted whose final result is not yet taken
   always_comb begin
      pending_in = pending_ff;
      if (req_take && !(rsp_take && rsp_last)) begin
         pending_in = pending_ff + 1'b1;
      end else if (!req_take && rsp_take && rsp_last) begin
         pending_in = pending_ff - 1'b1;
      end
      in_run_in = in_run_ff;
      if (rsp_take) begin
         in_run_in = !rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         in_run_ff  <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         in_run_ff  <= in_run_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_result_slot) && $stable(rsp_result_id) &&
      $stable(rsp_woken_value) && $stable(rsp_last))
      else $error("stalled result changed");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result without an outstanding item");

   a_run_woken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && in_run_ff |-> rsp_status == ST_OK)
      else $error("wake sequence continued with a non-wake result");

endmodule

bind thread_slot_table tst_checker u_tst_checker (.*);
